// ----- design/sstd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstd_pkg
// Shared types, codes and segment constants for the seven-segment scanner.
// ----------------------------------------------------------------------------
package sstd_pkg;

	localparam int BUF_DEPTH       = 8;
	localparam int POS_W           = 3;
	localparam int DIGIT_COUNT_DEF = 8;
	localparam int TEMP_W          = 16;
	localparam int VAL_W           = 14;

	typedef logic [7:0]                  seg_t;
	typedef logic [POS_W-1:0]            pos_t;
	typedef logic [BUF_DEPTH-1:0][7:0]   buf_t;

	// action codes
	localparam logic ACT_SET  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// latch targets
	localparam logic LATCH_SEG   = 1'b0;
	localparam logic LATCH_DIGIT = 1'b1;

	// active-low segment codes (bit7 = dp ... bit0 = a)
	localparam seg_t CODE_BLANK = 8'hFF;
	localparam seg_t CODE_MINUS = 8'hBF;
	localparam seg_t CODE_A     = 8'h88;
	localparam seg_t CODE_B     = 8'h83;
	localparam seg_t DP_MASK    = 8'h7F;
	localparam logic [7:0]       LABEL_A  = 8'd65;
	localparam logic [VAL_W-1:0] TEMP_MAX = 14'd9999;

	// one scan tick handed to the beat generator
	typedef struct packed {
		pos_t pos;
		seg_t seg;
	} tick_t;

	function automatic seg_t digit_code(input logic [3:0] d);
		seg_t c;
		case (d)
			4'd0:    c = 8'hC0;
			4'd1:    c = 8'hF9;
			4'd2:    c = 8'hA4;
			4'd3:    c = 8'hB0;
			4'd4:    c = 8'h99;
			4'd5:    c = 8'h92;
			4'd6:    c = 8'h82;
			4'd7:    c = 8'hF8;
			4'd8:    c = 8'h80;
			4'd9:    c = 8'h90;
			default: c = CODE_BLANK;
		endcase
		return c;
	endfunction

endpackage

// ----- design/sstd_item_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstd_item_if
// Input channel: set-temperature and scan-tick beats.
// ----------------------------------------------------------------------------
interface sstd_item_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [7:0]  label_char;
	logic [15:0] temp_hundredths;
	logic        negative;

	modport source (output valid, action, label_char, temp_hundredths, negative,
		input ready);
	modport sink (input valid, action, label_char, temp_hundredths, negative,
		output ready);
endinterface

// ----- design/sstd_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstd_result_if
// Output channel: one latch write per beat.
// ----------------------------------------------------------------------------
interface sstd_result_if;
	logic       valid;
	logic       ready;
	logic       latch;
	logic [7:0] latch_data;
	logic       last;

	modport source (output valid, latch, latch_data, last, input ready);
	modport sink (input valid, latch, latch_data, last, output ready);
endinterface

// ----- design/seven_segment_temp_display_scanner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_temp_display_scanner
// Eight-digit multiplexed seven-segment driver with a temperature image.
//
//   Channel  Dir  Fields                                           Beats/item
//   items    in   action, label_char, temp_hundredths, negative    1
//   results  out  latch, latch_data, last                          0 or 3
//
// A set-temperature beat is registered, encoded in one pass and written to
// the segment buffer on the next edge; it yields no result and one can be
// taken every cycle. A scan tick yields three result beats from the output
// sequencer, which takes the next tick as the final beat leaves. Set beats keep
// flowing while results wait; a tick that finds the sequencer busy holds the
// input register and stalls the input until the final beat leaves. Reset
// blanks the buffer and returns the scan position to digit zero.
// ----------------------------------------------------------------------------
module seven_segment_temp_display_scanner #(
	parameter int DIGIT_COUNT = sstd_pkg::DIGIT_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	sstd_item_if.sink     items,
	sstd_result_if.source results
);

	// input register stage
	logic        valid_s1;
	logic        action_s1;
	logic [7:0]  label_s1;
	logic [15:0] temp_s1;
	logic        neg_s1;

	// segment buffer and scan position
	sstd_pkg::buf_t  seg_buf_q;
	sstd_pkg::pos_t  pos_q;
	sstd_pkg::buf_t  image;

	sstd_pkg::tick_t tick;
	logic            free;
	logic            is_tick_s1;
	logic            load;
	logic            adv_s1;

	assign is_tick_s1 = (action_s1 == sstd_pkg::ACT_TICK);
	// hand a tick on only once the sequencer can take it
	assign load   = valid_s1 && is_tick_s1 && free;
	// a set beat always retires; a tick retires when loaded
	assign adv_s1 = valid_s1 && (!is_tick_s1 || free);
	assign items.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	// payload: no reset, capture on every accepted beat
	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			action_s1 <= items.action;
			label_s1  <= items.label_char;
			temp_s1   <= items.temp_hundredths;
			neg_s1    <= items.negative;
		end
	end

	sstd_encoder u_encoder (
		.label_char      (label_s1),
		.temp_hundredths (temp_s1),
		.negative        (neg_s1),
		.image           (image)
	);

	// rewrite the whole buffer on a set beat; wrap the scan position on a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_buf_q <= {sstd_pkg::BUF_DEPTH{sstd_pkg::CODE_BLANK}};
			pos_q     <= '0;
		end else begin
			if (valid_s1 && !is_tick_s1) begin
				seg_buf_q <= image;
			end
			if (load) begin
				if (pos_q == sstd_pkg::POS_W'(DIGIT_COUNT - 1)) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	// snapshot the digit byte now; later set beats must not touch this tick
	assign tick.pos = pos_q;
	assign tick.seg = seg_buf_q[pos_q];

	sstd_beat_gen u_beat_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.tick    (tick),
		.free    (free),
		.results (results)
	);

	// scan position never reaches the digit count
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= sstd_pkg::POS_W'(DIGIT_COUNT - 1))
		else $error("scan position out of range");

	// a digit select beat is always followed by the segment beat
	a_select_then_seg: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.ready && results.latch == sstd_pkg::LATCH_DIGIT
		|=> results.valid && results.last)
		else $error("segment beat missing after digit select");

	// the final beat drains the sequencer unless a new tick loads
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.ready && results.last && !load |=> !results.valid)
		else $error("sequencer did not drain after last beat");

	// a tick blocked by a busy sequencer stays in the input register
	a_tick_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && is_tick_s1 && !free |=> valid_s1 && is_tick_s1)
		else $error("stalled tick was lost");

endmodule

// ----- design/sstd_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstd_encoder
// Builds the eight-entry segment image from label, sign and temperature.
// ----------------------------------------------------------------------------
module sstd_encoder (
	input  logic [7:0]              label_char,
	input  logic [15:0]             temp_hundredths,
	input  logic                    negative,
	output sstd_pkg::buf_t          image
);

	localparam logic [12:0] RECIP_100 = 13'd5243;   // 2^19 / 100, rounded up

	// split 0..99 into tens and units: tens = (x * 205) >> 11
	function automatic logic [7:0] split_tens(input logic [6:0] x);
		logic [14:0] p;
		logic [3:0]  t;
		logic [6:0]  u;
		p = 15'(x) * 15'd205;
		t = p[14:11];
		u = x - 7'(7'(t) * 7'd10);
		return {t, u[3:0]};
	endfunction

	logic [sstd_pkg::VAL_W-1:0] val;
	logic [26:0]                prod_hi;
	logic [6:0]                 hi;
	logic [sstd_pkg::VAL_W-1:0] hi100;
	logic [sstd_pkg::VAL_W-1:0] lo_w;
	logic [7:0]                 hi_d;
	logic [7:0]                 lo_d;

	always_comb begin
		if (temp_hundredths > 16'(sstd_pkg::TEMP_MAX)) begin
			val = sstd_pkg::TEMP_MAX;
		end else begin
			val = temp_hundredths[sstd_pkg::VAL_W-1:0];
		end
		prod_hi = 27'(val) * 27'(RECIP_100);
		hi      = prod_hi[25:19];
		hi100   = 14'(hi) * 14'd100;
		lo_w    = val - hi100;
		hi_d    = split_tens(hi);
		lo_d    = split_tens(lo_w[6:0]);

		image[0] = (label_char == sstd_pkg::LABEL_A) ? sstd_pkg::CODE_A : sstd_pkg::CODE_B;
		image[1] = negative ? sstd_pkg::CODE_MINUS : sstd_pkg::CODE_BLANK;
		image[2] = sstd_pkg::CODE_BLANK;
		image[3] = sstd_pkg::CODE_BLANK;
		image[4] = sstd_pkg::digit_code(hi_d[7:4]);
		image[5] = sstd_pkg::digit_code(hi_d[3:0]) & sstd_pkg::DP_MASK;
		image[6] = sstd_pkg::digit_code(lo_d[7:4]);
		image[7] = sstd_pkg::digit_code(lo_d[3:0]);
	end

endmodule

// ----- design/sstd_beat_gen.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstd_beat_gen
// Plays one scan tick out as three latch-write beats.
// ----------------------------------------------------------------------------
module sstd_beat_gen (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  sstd_pkg::tick_t        tick,
	output logic                   free,
	sstd_result_if.source          results
);

	typedef enum logic [1:0] {
		BEAT_BLANK,
		BEAT_SELECT,
		BEAT_SEGMENT
	} beat_t;

	logic           valid_q;
	beat_t          beat_q;
	sstd_pkg::pos_t pos_q;
	sstd_pkg::seg_t seg_q;
	logic           take;

	assign take = results.valid && results.ready;
	// free when idle or when the final beat leaves this cycle
	assign free = !valid_q || (take && beat_q == BEAT_SEGMENT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= BEAT_BLANK;
			pos_q   <= '0;
			seg_q   <= sstd_pkg::CODE_BLANK;
		end else if (load) begin
			valid_q <= 1'b1;
			beat_q  <= BEAT_BLANK;
			pos_q   <= tick.pos;
			seg_q   <= tick.seg;
		end else if (take) begin
			case (beat_q)
				BEAT_BLANK:   beat_q  <= BEAT_SELECT;
				BEAT_SELECT:  beat_q  <= BEAT_SEGMENT;
				BEAT_SEGMENT: valid_q <= 1'b0;
				default:      valid_q <= 1'b0;
			endcase
		end
	end

	always_comb begin
		results.valid = valid_q;
		case (beat_q)
			BEAT_BLANK: begin
				results.latch      = sstd_pkg::LATCH_SEG;
				results.latch_data = sstd_pkg::CODE_BLANK;
				results.last       = 1'b0;
			end
			BEAT_SELECT: begin
				results.latch      = sstd_pkg::LATCH_DIGIT;
				results.latch_data = ~(8'd1 << pos_q);
				results.last       = 1'b0;
			end
			BEAT_SEGMENT: begin
				results.latch      = sstd_pkg::LATCH_SEG;
				results.latch_data = seg_q;
				results.last       = 1'b1;
			end
			default: begin
				results.latch      = sstd_pkg::LATCH_SEG;
				results.latch_data = sstd_pkg::CODE_BLANK;
				results.last       = 1'b0;
			end
		endcase
	end

endmodule

// ----- dv/seven_segment_temp_display_scanner_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_temp_display_scanner_tb
// Self-checking bench for the eight-digit temperature display scanner. Fills
// a command queue with directed and random set-temperature and scan-tick
// beats and drives them with random gaps. A shadow copy of the segment buffer
// and the scan position, updated on every accepted command, predicts each
// latch write. A monitor checks each write field by field against the
// oldest prediction while the receiver stalls at random.
// ----------------------------------------------------------------------------
module seven_segment_temp_display_scanner_tb;

	localparam int DIGIT_COUNT = 8;
	localparam int CLK_HALF    = 10;
	localparam int RESET_CYCLES = 10;
	localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
	localparam int QUIET_LIMIT  = 3000;   // cycles with no beat on either side
	localparam int TAIL_CYCLES  = 20;     // settle time after the last write
	localparam int REPORT_MAX   = 10;

	// active-low glyphs for 0..9, index 0 in the low byte
	localparam logic [9:0][7:0] GLYPH = {
		8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
	};

	typedef struct packed {
		logic        action;
		logic [7:0]  label_char;
		logic [15:0] temp_hundredths;
		logic        negative;
	} display_cmd_t;

	typedef struct packed {
		logic       latch;
		logic [7:0] latch_data;
		logic       last;
	} latch_write_t;

	logic clk;
	logic arst_n;

	sstd_item_if   items_ch ();
	sstd_result_if results_ch ();

	seven_segment_temp_display_scanner #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_ch),
		.results(results_ch)
	);

	// commands waiting to be offered, and latch writes waiting to be seen
	display_cmd_t cmd_queue[$];
	latch_write_t pending_writes[$];

	// shadow of the display state, advanced on each accepted command
	sstd_pkg::seg_t shadow_buf [sstd_pkg::BUF_DEPTH];
	sstd_pkg::pos_t shadow_pos;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	logic hold_kick;
	int quiet_cycles = 0;
	int err_count = 0;

	// ------------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Prediction: fold one accepted command into the shadow state and queue
	// the latch writes it causes. A set rewrites the whole image and yields
	// nothing; a tick yields blank, digit select, segment byte, then advances.
	// ------------------------------------------------------------------------
	function automatic void model_display_cmd(input display_cmd_t cmd);
		logic [15:0] shown;
		if (cmd.action == sstd_pkg::ACT_SET) begin
			// saturate at 99.99
			shown = (cmd.temp_hundredths > sstd_pkg::TEMP_MAX) ?
				16'(sstd_pkg::TEMP_MAX) : cmd.temp_hundredths;
			shadow_buf[0] = (cmd.label_char == sstd_pkg::LABEL_A) ?
				sstd_pkg::CODE_A : sstd_pkg::CODE_B;
			shadow_buf[1] = cmd.negative ? sstd_pkg::CODE_MINUS : sstd_pkg::CODE_BLANK;
			shadow_buf[2] = sstd_pkg::CODE_BLANK;
			shadow_buf[3] = sstd_pkg::CODE_BLANK;
			shadow_buf[4] = GLYPH[(shown / 1000) % 10];
			// decimal point rides on the hundreds digit
			shadow_buf[5] = GLYPH[(shown / 100) % 10] & sstd_pkg::DP_MASK;
			shadow_buf[6] = GLYPH[(shown / 10) % 10];
			shadow_buf[7] = GLYPH[shown % 10];
		end else begin
			pending_writes.push_back('{sstd_pkg::LATCH_SEG, sstd_pkg::CODE_BLANK, 1'b0});
			pending_writes.push_back('{sstd_pkg::LATCH_DIGIT, ~(8'd1 << shadow_pos), 1'b0});
			pending_writes.push_back('{sstd_pkg::LATCH_SEG, shadow_buf[shadow_pos], 1'b1});
			// wrap after the last digit
			if (int'(shadow_pos) + 1 >= DIGIT_COUNT)
				shadow_pos = '0;
			else
				shadow_pos = shadow_pos + 1'b1;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Driver: on each edge, note an accepted beat for prediction, then offer
	// the next queued command unless this cycle idles. Hold the beat steady
	// while the block stalls it. Reset blanks the shadow image.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_items
		display_cmd_t nxt;
		display_cmd_t seen;
		if (!arst_n) begin
			items_ch.valid <= 1'b0;
			shadow_pos = '0;
			for (int i = 0; i < sstd_pkg::BUF_DEPTH; i++)
				shadow_buf[i] = sstd_pkg::CODE_BLANK;
		end else begin
			if (items_ch.valid && items_ch.ready) begin
				seen.action          = items_ch.action;
				seen.label_char      = items_ch.label_char;
				seen.temp_hundredths = items_ch.temp_hundredths;
				seen.negative        = items_ch.negative;
				model_display_cmd(seen);
			end
			// a stalled beat stays on the bus untouched
			if (!(items_ch.valid && !items_ch.ready)) begin
				if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = cmd_queue.pop_front();
					items_ch.valid           <= 1'b1;
					items_ch.action          <= nxt.action;
					items_ch.label_char      <= nxt.label_char;
					items_ch.temp_hundredths <= nxt.temp_hundredths;
					items_ch.negative        <= nxt.negative;
				end else begin
					items_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver hold-off: count down a long stretch of ready low on request.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_kick && hold_left == 0) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check each accepted latch write against the oldest prediction,
	// then pick ready for the next cycle.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : watch_results
		latch_write_t got;
		latch_write_t want;
		if (!arst_n) begin
			results_ch.ready <= 1'b0;
		end else begin
			if (results_ch.valid && results_ch.ready) begin
				got = '{results_ch.latch, results_ch.latch_data, results_ch.last};
				if (pending_writes.size() == 0) begin
					err_count = err_count + 1;
					if (err_count <= REPORT_MAX)
						$display("%0t: unexpected latch write latch=%0d data=%02h last=%0d",
							$realtime, got.latch, got.latch_data, got.last);
				end else begin
					want = pending_writes.pop_front();
					if (got.latch !== want.latch || got.latch_data !== want.latch_data ||
						got.last !== want.last) begin
						err_count = err_count + 1;
						if (err_count <= REPORT_MAX)
							$display(
								"%0t: expected latch=%0d data=%02h last=%0d, got %0d %02h %0d",
								$realtime, want.latch, want.latch_data, want.last,
								got.latch, got.latch_data, got.last);
					end
				end
			end
			results_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run when neither side moves a beat for too long.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $realtime, QUIET_LIMIT);
				$display("seven_segment_temp_display_scanner_tb: done, errors");
				$finish;
			end
		end else begin
			quiet_cycles <= 0;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic void queue_cmd(input logic act, input logic [7:0] lbl,
		input logic [15:0] temp, input logic neg);
		cmd_queue.push_back('{act, lbl, temp, neg});
	endfunction

	// random temperature: mostly in range, some near the clamp, some anywhere
	function automatic logic [15:0] random_temp();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40)
			return 16'($urandom_range(9999));
		else if (pick < 60)
			return 16'($urandom_range(10010, 9990));
		else
			return 16'($urandom);
	endfunction

	// random label: 'A' often enough to matter, otherwise any byte
	function automatic logic [7:0] random_label();
		if ($urandom_range(3) == 0)
			return sstd_pkg::LABEL_A;
		return 8'($urandom_range(255));
	endfunction

	// Mostly frames: a set followed by a burst of ticks that scans part or
	// all of the new image. The rest are lone commands of either kind,
	// including back-to-back sets that overwrite an image before it shows.
	task automatic queue_random(input int count);
		int n;
		int burst;
		n = 0;
		while (n < count) begin
			if ($urandom_range(99) < 85) begin
				queue_cmd(sstd_pkg::ACT_SET, random_label(), random_temp(),
					1'($urandom_range(1)));
				burst = $urandom_range(12, 1);
				repeat (burst)
					queue_cmd(sstd_pkg::ACT_TICK, random_label(), random_temp(),
						1'($urandom_range(1)));
				n = n + 1 + burst;
			end else begin
				queue_cmd(1'($urandom_range(1)), random_label(), random_temp(),
					1'($urandom_range(1)));
				n = n + 1;
			end
		end
	endtask

	task automatic drain_commands();
		while (cmd_queue.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence. Everything here moves on the falling edge so that it
	// never races the clocked driver and monitor.
	// ------------------------------------------------------------------------
	initial begin
		hold_kick      = 1'b0;
		send_idle_pct  = 28;
		recv_stall_pct = 57;

		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Phase 1: sender idles lightly, receiver heavily.
		// Scan the blank image after reset through every digit, so the position wraps back to digit zero.
		repeat (DIGIT_COUNT)
			queue_cmd(sstd_pkg::ACT_TICK, 8'h00, 16'h0000, 1'b0);
		// zero, label A, positive, then show the full image once
		queue_cmd(sstd_pkg::ACT_SET, sstd_pkg::LABEL_A, 16'd0, 1'b0);
		repeat (DIGIT_COUNT)
			queue_cmd(sstd_pkg::ACT_TICK, 8'hFF, 16'hFFFF, 1'b1);
		// overwrite twice before any tick: full-scale and just past the clamp
		queue_cmd(sstd_pkg::ACT_SET, 8'd66, 16'hFFFF, 1'b1);
		queue_cmd(sstd_pkg::ACT_SET, 8'hFF, 16'd10000, 1'b0);
		// exactly at the clamp, label 0, minus sign; scan label, sign, blanks
		queue_cmd(sstd_pkg::ACT_SET, 8'h00, 16'd9999, 1'b1);
		repeat (4)
			queue_cmd(sstd_pkg::ACT_TICK, 8'h41, 16'h5555, 1'b0);
		queue_random(120);
		drain_commands();

		// Phase 2: roles swapped.
		send_idle_pct  = 57;
		recv_stall_pct = 28;
		queue_random(120);
		drain_commands();

		// Phase 3: no idling; open with a long receiver hold-off so the block
		// backs up and stalls its input while ticks keep coming.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_kick = 1'b1;
		@(negedge clk);
		hold_kick = 1'b0;
		repeat (40)
			queue_cmd(sstd_pkg::ACT_TICK, random_label(), random_temp(),
				1'($urandom_range(1)));
		queue_random(120);
		drain_commands();

		// wait for the last beat to go out, then for every predicted write
		while (items_ch.valid)
			@(negedge clk);
		while (pending_writes.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (err_count == 0 && pending_writes.size() == 0) begin
			$display("seven_segment_temp_display_scanner_tb: done, clean");
		end else begin
			$display("seven_segment_temp_display_scanner_tb: done, errors");
		end
		$finish;
	end

endmodule

// ----- seven_segment_temp_display_scanner.f -----
design/sstd_pkg.sv
design/sstd_item_if.sv
design/sstd_result_if.sv
design/sstd_encoder.sv
design/sstd_beat_gen.sv
design/seven_segment_temp_display_scanner.sv
dv/seven_segment_temp_display_scanner_tb.sv
